// ----- rtl/rle4_pkg.sv -----
`timescale 1ns / 1ps

package rle4_pkg;

  // Image size limits and palette depth.
  localparam int MAX_WIDTH     = 64;
  localparam int MAX_HEIGHT    = 32;
  localparam int PALETTE_DEPTH = 16;

  // The cursor column runs 0..MAX_WIDTH and the cursor row 0..MAX_HEIGHT.
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  // Working width for cursor arithmetic: a cursor plus a byte plus one.
  localparam int SUM_W = 10;

  localparam int COLOR_W = 24;
  localparam int CFG_WIDTH_W  = 7;
  localparam int CFG_HEIGHT_W = 6;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 7'd12;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 6'd12;

  // Register selects (address bit 2).
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Input command codes.
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_PALETTE = 1'b1;

  // Escape codes following a zero count byte.
  localparam logic [7:0] ESC_EOL   = 8'h00;
  localparam logic [7:0] ESC_EOI   = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_RUNVAL,
    PH_ESCAPE,
    PH_DELTA_X,
    PH_DELTA_Y,
    PH_ABS,
    PH_PAD
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL
  } state_e;

  typedef enum logic [1:0] {
    TGT_NONE,
    TGT_EOL,
    TGT_EOI,
    TGT_DELTA
  } target_e;

  typedef struct packed {
    logic    pal_we;
    logic    byte_ld;
    logic    rd_run;
    logic    ld_held;
    logic    ld_abs;
    logic    ld_skip;
    logic    abs_step;
    logic    put_sel_abs;
    logic    put_go;
    logic    fill_step;
    logic    emit;
    logic    cur_clr;
    target_e tgt;
  } dp_cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic byte_one;
    logic byte_two;
    logic put_emits;
    logic abs_last;
    logic abs_pad;
    logic fill_cont;
    logic fill_emits;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [4:0]         row;
    logic [5:0]         start_col;
    logic [6:0]         pixel_count;
    logic [COLOR_W-1:0] color_even;
    logic [COLOR_W-1:0] color_odd;
    logic               row_done;
    logic               image_done;
    logic               clipped;
  } segment_t;

endpackage

// ----- rtl/rle4_ctrl.sv -----
`timescale 1ns / 1ps

module rle4_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 cmd_i,
  output logic                 in_stall_o,
  input  rle4_pkg::dp_status_t status_i,
  output rle4_pkg::dp_cmd_t    dp_cmd_o
);
  import rle4_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   eoi_q, eoi_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_COUNT;
      eoi_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      eoi_q   <= eoi_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    eoi_d    = eoi_q;
    dp_cmd_o = '0;
    dp_cmd_o.tgt = TGT_NONE;
    dp_cmd_o.put_sel_abs = (phase_q == PH_ABS);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_PALETTE) begin
            dp_cmd_o.pal_we = 1'b1;
          end else begin
            dp_cmd_o.byte_ld = 1'b1;
            dp_cmd_o.rd_run  = (phase_q == PH_RUNVAL) || (phase_q == PH_ABS);
            state_d = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        unique case (phase_q)
          PH_COUNT: begin
            if (status_i.byte_zero) begin
              phase_d = PH_ESCAPE;
            end else begin
              dp_cmd_o.ld_held = 1'b1;
              phase_d = PH_RUNVAL;
            end
            state_d = ST_IDLE;
          end
          PH_RUNVAL: begin
            if (!status_i.put_emits || status_i.out_free) begin
              dp_cmd_o.put_go = 1'b1;
              dp_cmd_o.emit   = status_i.put_emits;
              phase_d = PH_COUNT;
              state_d = ST_IDLE;
            end
          end
          PH_ESCAPE: begin
            phase_d = PH_COUNT;
            if (status_i.byte_zero) begin
              dp_cmd_o.tgt = TGT_EOL;
              eoi_d   = 1'b0;
              state_d = ST_FILL;
            end else if (status_i.byte_one) begin
              dp_cmd_o.tgt = TGT_EOI;
              eoi_d   = 1'b1;
              state_d = ST_FILL;
            end else if (status_i.byte_two) begin
              phase_d = PH_DELTA_X;
              state_d = ST_IDLE;
            end else begin
              dp_cmd_o.ld_abs = 1'b1;
              phase_d = PH_ABS;
              state_d = ST_IDLE;
            end
          end
          PH_DELTA_X: begin
            dp_cmd_o.ld_skip = 1'b1;
            phase_d = PH_DELTA_Y;
            state_d = ST_IDLE;
          end
          PH_DELTA_Y: begin
            dp_cmd_o.tgt = TGT_DELTA;
            eoi_d   = 1'b0;
            phase_d = PH_COUNT;
            state_d = ST_FILL;
          end
          PH_ABS: begin
            if (!status_i.put_emits || status_i.out_free) begin
              dp_cmd_o.put_go   = 1'b1;
              dp_cmd_o.emit     = status_i.put_emits;
              dp_cmd_o.abs_step = 1'b1;
              if (status_i.abs_last) begin
                phase_d = status_i.abs_pad ? PH_PAD : PH_COUNT;
              end
              state_d = ST_IDLE;
            end
          end
          default: begin
            // The pad byte after an absolute run with an odd number of data bytes, and unused codes.
            phase_d = PH_COUNT;
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_FILL: begin
        if (!status_i.fill_cont) begin
          dp_cmd_o.cur_clr = eoi_q;
          state_d = ST_IDLE;
        end else if (!status_i.fill_emits || status_i.out_free) begin
          dp_cmd_o.fill_step = 1'b1;
          dp_cmd_o.emit      = status_i.fill_emits;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/rle4_dp.sv -----
`timescale 1ns / 1ps

module rle4_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rle4_pkg::dp_cmd_t    dp_cmd_i,
  output rle4_pkg::dp_status_t status_o,
  input  logic [7:0]           data_byte_i,
  input  logic [3:0]           palette_index_i,
  input  logic [23:0]          palette_color_i,
  input  logic [6:0]           image_width_i,
  input  logic [5:0]           image_height_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output rle4_pkg::segment_t   seg_o
);
  import rle4_pkg::*;

  // Palette: two read ports, registered read data.
  logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] col_a_q, col_b_q;
  logic [PAL_AW-1:0]  addr_a, addr_b;

  // Port A reads entry 0 unless the byte carries pixel nibbles.
  assign addr_a = dp_cmd_i.rd_run ? data_byte_i[7:4] : '0;
  assign addr_b = data_byte_i[3:0];

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.pal_we) begin
      pal_mem[palette_index_i] <= palette_color_i;
    end
    if (dp_cmd_i.byte_ld) begin
      col_a_q <= pal_mem[addr_a];
      col_b_q <= pal_mem[addr_b];
    end
  end

  logic [7:0]       byte_q, held_q, held_d, left_q, left_d, skip_q, skip_d;
  logic [ROW_W-1:0] row_q, row_d, trow_q;
  logic [COL_W-1:0] col_q, col_d, tcol_q;
  logic             out_valid_q;
  segment_t         seg_q, seg_d;

  logic [SUM_W-1:0] w_raw, h_raw, w_eff, h_eff;
  logic [SUM_W-1:0] row_e, col_e, trow_e, tcol_e;
  logic [SUM_W-1:0] avail, k_abs, put_n, put_k, fill_k, seg_k;
  logic [SUM_W-1:0] delta_c, delta_r, tr, tc, tr_c, tc_c;
  logic [8:0]       held_inc;
  logic [7:0]       k_abs8;
  logic             row_in, put_clip, row_before, fill_cont, fill_emits;
  logic             seg_rd, out_free;
  logic [COLOR_W-1:0] seg_co;

  assign w_raw  = SUM_W'(image_width_i);
  assign h_raw  = SUM_W'(image_height_i);
  assign w_eff  = (w_raw == '0) ? SUM_W'(1) :
                  ((w_raw > SUM_W'(MAX_WIDTH)) ? SUM_W'(MAX_WIDTH) : w_raw);
  assign h_eff  = (h_raw == '0) ? SUM_W'(1) :
                  ((h_raw > SUM_W'(MAX_HEIGHT)) ? SUM_W'(MAX_HEIGHT) : h_raw);

  assign row_e  = SUM_W'(row_q);
  assign col_e  = SUM_W'(col_q);
  assign trow_e = SUM_W'(trow_q);
  assign tcol_e = SUM_W'(tcol_q);

  // Placing a run at the cursor.
  assign row_in   = row_e < h_eff;
  assign avail    = (col_e < w_eff) ? (w_eff - col_e) : '0;
  assign k_abs8   = (left_q >= 8'd2) ? 8'd2 : 8'd1;
  assign k_abs    = SUM_W'(k_abs8);
  assign put_n    = dp_cmd_i.put_sel_abs ? k_abs : SUM_W'(held_q);
  assign put_clip = put_n > avail;
  assign put_k    = put_clip ? avail : put_n;

  // Filling towards the target with entry 0, one row at a time.
  assign row_before = row_e < trow_e;
  assign fill_cont  = row_in && (row_before || (col_e < tcol_e));
  assign fill_emits = fill_cont && (!row_before || (col_e < w_eff));
  assign fill_k     = row_before ? (w_eff - col_e) : (tcol_e - col_e);

  assign seg_k  = dp_cmd_i.fill_step ? fill_k : put_k;
  assign seg_co = dp_cmd_i.fill_step ? col_a_q : col_b_q;
  assign seg_rd = (col_e + seg_k) == w_eff;

  assign held_inc = {1'b0, held_q} + 9'd1;

  assign status_o.byte_zero  = (byte_q == ESC_EOL);
  assign status_o.byte_one   = (byte_q == ESC_EOI);
  assign status_o.byte_two   = (byte_q == ESC_DELTA);
  assign status_o.put_emits  = row_in && (put_k != '0);
  assign status_o.abs_last   = (left_q <= 8'd2);
  assign status_o.abs_pad    = held_inc[1];
  assign status_o.fill_cont  = fill_cont;
  assign status_o.fill_emits = fill_emits;
  assign status_o.out_free   = out_free;

  // Fill target, clamped to the image.
  assign delta_c = col_e + SUM_W'(skip_q);
  assign delta_r = row_e + SUM_W'(byte_q);

  always_comb begin
    unique case (dp_cmd_i.tgt)
      TGT_EOL: begin
        tr = row_e + SUM_W'(1);
        tc = '0;
      end
      TGT_EOI: begin
        tr = h_eff;
        tc = '0;
      end
      TGT_DELTA: begin
        if (delta_c >= w_eff) begin
          tr = delta_r + SUM_W'(1);
          tc = '0;
        end else begin
          tr = delta_r;
          tc = delta_c;
        end
      end
      default: begin
        tr = trow_e;
        tc = tcol_e;
      end
    endcase
    tr_c = tr;
    tc_c = tc;
    if (tr >= h_eff) begin
      tr_c = h_eff;
      tc_c = '0;
    end
    if (tc_c > w_eff) begin
      tc_c = w_eff;
    end
  end

  // Cursor and parse registers.
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    held_d = held_q;
    left_d = left_q;
    skip_d = skip_q;
    if (dp_cmd_i.cur_clr) begin
      row_d = '0;
      col_d = '0;
    end else if (dp_cmd_i.fill_step && fill_cont) begin
      if (row_before) begin
        row_d = ROW_W'(row_e + SUM_W'(1));
        col_d = '0;
      end else begin
        col_d = tcol_q;
      end
    end else if (dp_cmd_i.put_go && status_o.put_emits) begin
      col_d = COL_W'(col_e + put_k);
    end
    if (dp_cmd_i.ld_held || dp_cmd_i.ld_abs) begin
      held_d = byte_q;
    end
    if (dp_cmd_i.ld_abs) begin
      left_d = byte_q;
    end else if (dp_cmd_i.abs_step) begin
      left_d = (left_q > k_abs8) ? (left_q - k_abs8) : 8'd0;
    end
    if (dp_cmd_i.ld_skip) begin
      skip_d = byte_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      held_q <= '0;
      left_q <= '0;
      skip_q <= '0;
      trow_q <= '0;
      tcol_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      held_q <= held_d;
      left_q <= left_d;
      skip_q <= skip_d;
      if (dp_cmd_i.tgt != TGT_NONE) begin
        trow_q <= ROW_W'(tr_c);
        tcol_q <= COL_W'(tc_c);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.byte_ld) begin
      byte_q <= data_byte_i;
    end
  end

  // Output register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    seg_d.row         = row_e[4:0];
    seg_d.start_col   = col_e[5:0];
    seg_d.pixel_count = seg_k[6:0];
    seg_d.color_even  = col_a_q;
    seg_d.color_odd   = (seg_k == SUM_W'(1)) ? '0 : seg_co;
    seg_d.row_done    = seg_rd;
    seg_d.image_done  = seg_rd && ((row_e + SUM_W'(1)) == h_eff);
    seg_d.clipped     = !dp_cmd_i.fill_step && put_clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dp_cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.emit) begin
      seg_q <= seg_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign seg_o       = seg_q;

endmodule

// ----- rtl/rle4_bitmap_row_decoder.sv -----
`timescale 1ns / 1ps
// A value byte is latched with its palette read when it is accepted, and the
// execute step then places its run in the output register. An escape code is latched,
// decoded in the execute step, and its fill then walks the steps to the target. A
// new data byte is held off (in_stall_o) until the last one is done; palette writes
// need no execute step and can follow each other. A fill step is a row passed or
// the part of a row up to a delta's target; output stalls hold both runs and fills.
// Reset (rst_ni, asynchronous, active low) clears the parse and the cursor and
// sets the image to 12 by 12; the palette holds garbage until it is written.
module rle4_bitmap_row_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [3:0]  palette_index_i,
  input  logic [23:0] palette_color_i,
  // Output channel, one segment per beat.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  row_o,
  output logic [5:0]  start_col_o,
  output logic [6:0]  pixel_count_o,
  output logic [23:0] color_even_o,
  output logic [23:0] color_odd_o,
  output logic        row_done_o,
  output logic        image_done_o,
  output logic        clipped_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rle4_pkg::*;

  // The image size registers. Address bit 2 selects the register; the low
  // two bits are the byte offset within the word and are not decoded.
  logic [CFG_WIDTH_W-1:0]  width_q;
  logic [CFG_HEIGHT_W-1:0] height_q;
  logic                    cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_WIDTH) begin
        width_q <= pwdata[CFG_WIDTH_W-1:0];
      end else begin
        height_q <= pwdata[CFG_HEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  // The controller sequences each byte: the accept cycle starts the palette
  // read, the execute cycle updates the parse and places a run, and a fill
  // walks the rows to its target giving at most one segment per row.
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  segment_t   seg;

  rle4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .dp_cmd_o   (dp_cmd)
  );

  rle4_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dp_cmd_i        (dp_cmd),
    .status_o        (dp_status),
    .data_byte_i     (data_byte_i),
    .palette_index_i (palette_index_i),
    .palette_color_i (palette_color_i),
    .image_width_i   (width_q),
    .image_height_i  (height_q),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .seg_o           (seg)
  );

  assign row_o         = seg.row;
  assign start_col_o   = seg.start_col;
  assign pixel_count_o = seg.pixel_count;
  assign color_even_o  = seg.color_even;
  assign color_odd_o   = seg.color_odd;
  assign row_done_o    = seg.row_done;
  assign image_done_o  = seg.image_done;
  assign clipped_o     = seg.clipped;

endmodule

// ----- sim/rle4_bitmap_row_decoder_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the 4-bit run-length row decoder. Encoded bytes and
// palette writes go in as beats on the input channel. Each segment beat that
// comes out is checked against a local decoder model, field by field, in order.
module rle4_bitmap_row_decoder_tb;
  import rle4_pkg::*;

  localparam int PHASES        = 7;
  localparam int PHASE_BEATS   = 60;
  // Lets a trailing fill end once nothing is pending. This covers the worst case
  // with plenty to spare, before any register write and at the end of the run.
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [2:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic        cmd_i           = CMD_DATA;
  logic [7:0]  data_byte_i     = 8'h00;
  logic [3:0]  palette_index_i = 4'h0;
  logic [23:0] palette_color_i = 24'h000000;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [4:0]  row_o;
  logic [5:0]  start_col_o;
  logic [6:0]  pixel_count_o;
  logic [23:0] color_even_o;
  logic [23:0] color_odd_o;
  logic        row_done_o;
  logic        image_done_o;
  logic        clipped_o;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = 3'b000;
  logic [31:0] pwdata          = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  rle4_bitmap_row_decoder dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Local copy of the decoder: palette, parse phase, cursor and registers.
  logic [23:0]             palette_q [PALETTE_DEPTH];
  phase_e                  phase_q  = PH_COUNT;
  logic [7:0]              held_q   = 8'h00;
  logic [7:0]              left_q   = 8'h00;
  logic [7:0]              skip_q   = 8'h00;
  int unsigned             row_q    = 0;
  int unsigned             col_q    = 0;
  logic [CFG_WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
  logic [CFG_HEIGHT_W-1:0] height_reg = HEIGHT_RESET;

  segment_t segments_due [$];
  segment_t seen;
  int       emitted;
  int       idle_pct    = 15;
  int       phase_beats = 0;
  int       mismatches  = 0;
  int       cycles      = 0;

  assign seen = {row_o, start_col_o, pixel_count_o, color_even_o, color_odd_o,
                 row_done_o, image_done_o, clipped_o};

  function automatic int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned used_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(height_reg);
  endfunction

  // Queues a segment of k pixels at the cursor and moves the cursor past it.
  function automatic void emit_segment(int unsigned k, logic [23:0] ce, logic [23:0] co,
                                       logic clip);
    segment_t s;
    s.row         = row_q[4:0];
    s.start_col   = col_q[5:0];
    s.pixel_count = k[6:0];
    s.color_even  = ce;
    s.color_odd   = (k == 1) ? 24'h000000 : co;
    s.row_done    = (col_q + k == used_width());
    s.image_done  = s.row_done && (row_q + 1 == used_height());
    s.clipped     = clip;
    segments_due.push_back(s);
    emitted++;
    col_q += k;
  endfunction

  // Pixels are cut at the row end; nothing is drawn below the image.
  function automatic void put_pixels(int unsigned n, logic [23:0] ce, logic [23:0] co);
    int unsigned avail;
    if (row_q >= used_height()) return;
    avail = (col_q < used_width()) ? used_width() - col_q : 0;
    if (n > avail) begin
      if (avail > 0) emit_segment(avail, ce, co, 1'b1);
    end else if (n > 0) begin
      emit_segment(n, ce, co, 1'b0);
    end
  endfunction

  // Background fill in raster order up to the target, at most one segment per row.
  function automatic void fill_to(int unsigned trow, int unsigned tcol);
    int unsigned w;
    int unsigned h;
    w = used_width();
    h = used_height();
    if (trow >= h) begin
      trow = h;
      tcol = 0;
    end
    if (tcol > w) tcol = w;
    while (row_q < h && (row_q < trow || col_q < tcol)) begin
      if (row_q < trow) begin
        if (col_q < w) emit_segment(w - col_q, palette_q[0], palette_q[0], 1'b0);
        row_q++;
        col_q = 0;
      end else begin
        emit_segment(tcol - col_q, palette_q[0], palette_q[0], 1'b0);
      end
    end
  endfunction

  // Advances the local decoder by one accepted beat; returns the segments queued.
  function automatic int decode_beat(logic c, logic [7:0] b, logic [3:0] pi,
                                     logic [23:0] pc);
    int unsigned tcol;
    int unsigned trow;
    int unsigned k;
    emitted = 0;
    if (c == CMD_PALETTE) begin
      palette_q[pi] = pc;
      return 0;
    end
    case (phase_q)
      PH_COUNT: begin
        if (b != 8'h00) begin
          held_q  = b;
          phase_q = PH_RUNVAL;
        end else begin
          phase_q = PH_ESCAPE;
        end
      end
      PH_RUNVAL: begin
        put_pixels(32'(held_q), palette_q[b[7:4]], palette_q[b[3:0]]);
        phase_q = PH_COUNT;
      end
      PH_ESCAPE: begin
        if (b == ESC_EOL) begin
          fill_to(row_q + 1, 0);
          phase_q = PH_COUNT;
        end else if (b == ESC_EOI) begin
          fill_to(used_height(), 0);
          row_q   = 0;
          col_q   = 0;
          phase_q = PH_COUNT;
        end else if (b == ESC_DELTA) begin
          phase_q = PH_DELTA_X;
        end else begin
          held_q  = b;
          left_q  = b;
          phase_q = PH_ABS;
        end
      end
      PH_DELTA_X: begin
        skip_q  = b;
        phase_q = PH_DELTA_Y;
      end
      PH_DELTA_Y: begin
        tcol = col_q + 32'(skip_q);
        trow = row_q + 32'(b);
        // A target at or past the row end wraps to the start of the next row.
        if (tcol >= used_width()) begin
          tcol = 0;
          trow++;
        end
        fill_to(trow, tcol);
        phase_q = PH_COUNT;
      end
      PH_ABS: begin
        k = (left_q >= 2) ? 2 : 1;
        put_pixels(k, palette_q[b[7:4]], palette_q[b[3:0]]);
        left_q = (left_q > k) ? 8'(left_q - k) : 8'h00;
        if (left_q == 0) begin
          // An odd number of data bytes is followed by one pad byte.
          phase_q = ((((held_q + 1) >> 1) & 1) != 0) ? PH_PAD : PH_COUNT;
        end
      end
      default: phase_q = PH_COUNT;
    endcase
    return emitted;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want) note_mismatch($sformatf("%s is %0h, %0h was due", name, got, want));
  endtask

  task automatic check_segment(input segment_t got);
    segment_t want;
    if (segments_due.size() == 0) begin
      note_mismatch($sformatf("segment at row %0d col %0d with nothing pending",
                              got.row, got.start_col));
      return;
    end
    want = segments_due.pop_front();
    compare_field("row", 32'(got.row), 32'(want.row));
    compare_field("start_col", 32'(got.start_col), 32'(want.start_col));
    compare_field("pixel_count", 32'(got.pixel_count), 32'(want.pixel_count));
    compare_field("color_even", 32'(got.color_even), 32'(want.color_even));
    compare_field("color_odd", 32'(got.color_odd), 32'(want.color_odd));
    compare_field("row_done", 32'(got.row_done), 32'(want.row_done));
    compare_field("image_done", 32'(got.image_done), 32'(want.image_done));
    compare_field("clipped", 32'(got.clipped), 32'(want.clipped));
  endtask

  // Outputs are sampled at the rising edge; the stall was set at the falling one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_segment(seen);
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < idle_pct);
  end

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segments pending", cycles,
               segments_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Drivers below are entered just after a falling edge and leave just after one.
  task automatic send_beat(input logic c, input logic [7:0] b, input logic [3:0] pi,
                           input logic [23:0] pc, output int produced);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= c;
    data_byte_i     <= b;
    palette_index_i <= pi;
    palette_color_i <= pc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    produced = decode_beat(c, b, pi, pc);
    phase_beats++;
    @(negedge clk_i);
  endtask

  // Data beat; the unused palette fields carry random values.
  task automatic send_data(input logic [7:0] b);
    int n;
    send_beat(CMD_DATA, b, 4'($urandom_range(0, 15)), 24'($urandom_range(0, 24'hFFFFFF)), n);
  endtask

  // Mostly well-formed runs and escapes with random content, plus some noise.
  task automatic send_random_sequence();
    int unsigned pick;
    int unsigned cnt;
    int unsigned nbytes;
    int          n;
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
      send_data(8'(cnt));
      send_data(8'($urandom_range(0, 255)));
    end else if (pick < 50) begin
      send_data(8'h00);
      send_data(ESC_EOL);
    end else if (pick < 55) begin
      send_data(8'h00);
      send_data(ESC_EOI);
    end else if (pick < 67) begin
      send_data(8'h00);
      send_data(ESC_DELTA);
      send_data(8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 15)));
      send_data(8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 2)));
    end else if (pick < 82) begin
      cnt    = ($urandom_range(0, 11) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 16);
      nbytes = (cnt + 1) / 2;
      send_data(8'h00);
      send_data(8'(cnt));
      repeat (nbytes) send_data(8'($urandom_range(0, 255)));
      if (nbytes % 2 == 1) send_data(8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      send_beat(CMD_PALETTE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                24'($urandom_range(0, 24'hFFFFFF)), n);
    end else begin
      send_data(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
  endtask

  // Waits for every pending segment, then lets any trailing fill finish.
  task automatic await_segments();
    while (segments_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data;
    logic [3:0]  pidx;
    logic [23:0] pcolor;
    logic        typed;
    segment_t    want;
  } stim_row_t;

  stim_row_t directed [$];

  function automatic void plain_row(logic c, logic [7:0] b, logic [3:0] pi, logic [23:0] pc);
    stim_row_t r;
    r        = '0;
    r.cmd    = c;
    r.data   = b;
    r.pidx   = pi;
    r.pcolor = pc;
    directed.push_back(r);
  endfunction

  // A data beat whose single segment is written out by hand.
  function automatic void typed_row(logic [7:0] b, logic [4:0] r_row, logic [5:0] r_col,
                                    logic [6:0] r_cnt, logic [23:0] ce, logic [23:0] co,
                                    logic rd, logic id, logic cl);
    stim_row_t r;
    r                  = '0;
    r.cmd              = CMD_DATA;
    r.data             = b;
    r.typed            = 1'b1;
    r.want.row         = r_row;
    r.want.start_col   = r_col;
    r.want.pixel_count = r_cnt;
    r.want.color_even  = ce;
    r.want.color_odd   = co;
    r.want.row_done    = rd;
    r.want.image_done  = id;
    r.want.clipped     = cl;
    directed.push_back(r);
  endfunction

  initial begin
    int                      n;
    logic [CFG_WIDTH_W-1:0]  nw;
    logic [CFG_HEIGHT_W-1:0] nh;
    logic [31:0]             rd;

    // Entry i holds i in every nibble, so colours can be read off the index.
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      plain_row(CMD_PALETTE, 8'hA5, i[3:0], 24'(24'h111111 * i));
    end
    // The image is 12 by 12 after reset.
    plain_row(CMD_DATA, 8'h05, 4'h0, 24'h0);
    typed_row(8'hF0, 5'd0, 6'd0, 7'd5, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0, 1'b0);
    // A run of 255 is cut at the end of the row.
    plain_row(CMD_DATA, 8'hFF, 4'h0, 24'h0);
    typed_row(8'h1E, 5'd0, 6'd5, 7'd7, 24'h111111, 24'hEEEEEE, 1'b1, 1'b0, 1'b1);
    // The row is full, so this run is dropped without a segment.
    plain_row(CMD_DATA, 8'h03, 4'h0, 24'h0);
    plain_row(CMD_DATA, 8'h22, 4'h0, 24'h0);
    // End of line on a full row only moves the cursor down.
    plain_row(CMD_DATA, 8'h00, 4'h0, 24'h0);
    plain_row(CMD_DATA, ESC_EOL, 4'h0, 24'h0);
    // A single pixel has no odd colour.
    plain_row(CMD_DATA, 8'h01, 4'h0, 24'h0);
    typed_row(8'hAB, 5'd1, 6'd0, 7'd1, 24'hAAAAAA, 24'h000000, 1'b0, 1'b0, 1'b0);
    // End of line fills the rest of the row with entry 0.
    plain_row(CMD_DATA, 8'h00, 4'h0, 24'h0);
    plain_row(CMD_DATA, ESC_EOL, 4'h0, 24'h0);
    // Delta of three right and two down fills two rows and part of a third.
    plain_row(CMD_DATA, 8'h00, 4'h0, 24'h0);
    plain_row(CMD_DATA, ESC_DELTA, 4'h0, 24'h0);
    plain_row(CMD_DATA, 8'h03, 4'h0, 24'h0);
    plain_row(CMD_DATA, 8'h02, 4'h0, 24'h0);
    // Absolute run of five pixels in three bytes, then its pad byte.
    plain_row(CMD_DATA, 8'h00, 4'h0, 24'h0);
    plain_row(CMD_DATA, 8'h05, 4'h0, 24'h0);
    plain_row(CMD_DATA, 8'h12, 4'h0, 24'h0);
    plain_row(CMD_DATA, 8'h34, 4'h0, 24'h0);
    plain_row(CMD_DATA, 8'h56, 4'h0, 24'h0);
    plain_row(CMD_DATA, 8'h77, 4'h0, 24'h0);
    // A new background colour mid-parse, then end of image fills with it.
    plain_row(CMD_PALETTE, 8'hFF, 4'h0, 24'h00A5C3);
    plain_row(CMD_DATA, 8'h00, 4'h0, 24'h0);
    plain_row(CMD_DATA, ESC_EOI, 4'h0, 24'h0);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      send_beat(directed[i].cmd, directed[i].data, directed[i].pidx, directed[i].pcolor, n);
      if (directed[i].typed) begin
        repeat (n) void'(segments_due.pop_back());
        segments_due.push_back(directed[i].want);
      end
    end

    // Each phase runs at one image size; the cursor carries over between them,
    // so a shrink lands part-way through an image.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        in_valid_i <= 1'b0;
        await_segments();
        case (p)
          1: begin nw = 7'd1;   nh = 6'd1;  end
          2: begin nw = 7'd64;  nh = 6'd32; end
          3: begin nw = 7'd0;   nh = 6'd0;  end
          4: begin nw = 7'd127; nh = 6'd63; end
          5: begin nw = 7'($urandom_range(2, 20)); nh = 6'($urandom_range(2, 12)); end
          default: begin nw = 7'($urandom_range(1, 64)); nh = 6'($urandom_range(1, 32)); end
        endcase
        reg_access(1'b1, ADDR_WIDTH, 32'(nw), rd);
        reg_access(1'b1, ADDR_HEIGHT, 32'(nh), rd);
        reg_access(1'b0, ADDR_WIDTH, 32'h0, rd);
        compare_field("image_width readback", rd, 32'(nw));
        reg_access(1'b0, ADDR_HEIGHT, 32'h0, rd);
        compare_field("image_height readback", rd, 32'(nh));
        psel    <= 1'b0;
        penable <= 1'b0;
        width_reg  = nw;
        height_reg = nh;
      end
      // The widest image runs with neither side idling.
      idle_pct    = (p == 2) ? 0 : 15;
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) send_random_sequence();
    end

    in_valid_i <= 1'b0;
    await_segments();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rle4_pkg.sv
rtl/rle4_ctrl.sv
rtl/rle4_dp.sv
rtl/rle4_bitmap_row_decoder.sv
sim/rle4_bitmap_row_decoder_tb.sv
